// ===== src/ncdm_pkg.sv =====
// ----------------------------------------------------------------------------
// NCO complex down-mixer package
// Payload types, fixed sample format, rounding and the sine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ncdm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STEP_BITS   = 32;
  localparam int SUM_BITS    = 2 * SAMPLE_BITS + 1;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd858993459;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Two pi in Q30, used only while the table is generated.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] AMPLITUDE  = 64'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_i;
    logic signed [SAMPLE_BITS-1:0] in_q;
    logic                          restart;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_i;
    logic signed [SAMPLE_BITS-1:0] out_q;
    logic                          clipped;
  } out_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clip;
  } rnd_t;

  // One entry of the quarter-wave sine table. The angle is taken in Q30 and
  // sin is a truncated Taylor series through the fifteenth power.
  function automatic logic [63:0] sine_entry(input int unsigned addr_bits,
                                             input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] s;
    x    = (TWO_PI_Q30 * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    s    = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        default: term = prod;
      endcase
      if ((n % 2) == 1) begin
        s = s - signed'(term);
      end else begin
        s = s + signed'(term);
      end
    end
    if (s < 0) begin
      s = '0;
    end
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
    end
    return (unsigned'(s) * AMPLITUDE + (64'd1 << 29)) >> 30;
  endfunction

  // Round to nearest with ties toward plus infinity, then clamp.
  function automatic rnd_t round_sat(input logic signed [SUM_BITS-1:0] acc);
    logic signed [SUM_BITS:0] biased;
    logic signed [SUM_BITS:0] shifted;
    logic signed [SUM_BITS:0] wide_max;
    logic signed [SUM_BITS:0] wide_min;
    rnd_t                     res;
    wide_max = (SUM_BITS+1)'(SAMPLE_MAX);
    wide_min = (SUM_BITS+1)'(SAMPLE_MIN);
    biased   = {acc[SUM_BITS-1], acc} + ((SUM_BITS+1)'(1) << (SAMPLE_BITS - 2));
    shifted  = biased >>> (SAMPLE_BITS - 1);
    res.clip = 1'b0;
    if (shifted > wide_max) begin
      res.value = SAMPLE_MAX;
      res.clip  = 1'b1;
    end else if (shifted < wide_min) begin
      res.value = SAMPLE_MIN;
      res.clip  = 1'b1;
    end else begin
      res.value = shifted[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/ncdm_nco.sv =====
// ----------------------------------------------------------------------------
// NCO phase accumulator
// Holds the tuning word and the carrier phase; yields the table address.
// ----------------------------------------------------------------------------
`default_nettype none

module ncdm_nco #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [ncdm_pkg::STEP_BITS-1:0] cfg_data,
  input  wire logic                           accept,
  input  wire logic                           restart,
  output logic      [TABLE_ADDR_BITS-1:0]     addr
);

  logic [ncdm_pkg::STEP_BITS-1:0] phase_step;
  logic [PHASE_BITS-1:0]          phase_acc;
  logic [PHASE_BITS-1:0]          phase_acc_next;
  logic [PHASE_BITS-1:0]          phase;

  // A restart request runs at phase zero and the count continues from there.
  always_comb begin
    phase          = restart ? '0 : phase_acc;
    phase_acc_next = phase + PHASE_BITS'(phase_step);
    addr           = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= ncdm_pkg::STEP_RESET;
      phase_acc  <= '0;
    end else begin
      if (cfg_valid) begin
        phase_step <= cfg_data;
      end
      if (accept) begin
        phase_acc <= phase_acc_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ncdm_sincos.sv =====
// ----------------------------------------------------------------------------
// NCO sine and cosine lookup
// Quarter-wave table with quadrant folding; registers sin and cos.
// ----------------------------------------------------------------------------
`default_nettype none

module ncdm_sincos #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  wire logic                                       clk,
  input  wire logic                                       en,
  input  wire logic        [TABLE_ADDR_BITS-1:0]          addr,
  output logic signed      [ncdm_pkg::SAMPLE_BITS-1:0]    sin_val,
  output logic signed      [ncdm_pkg::SAMPLE_BITS-1:0]    cos_val
);

  localparam int SB   = ncdm_pkg::SAMPLE_BITS;
  localparam int QTR  = 1 << (TABLE_ADDR_BITS - 2);
  localparam int IDXW = TABLE_ADDR_BITS - 1;

  logic [SB-2:0] qtab [QTR+1];

  for (genvar k = 0; k <= QTR; k++) begin : g_tab
    localparam logic [63:0] ENTRY = ncdm_pkg::sine_entry(TABLE_ADDR_BITS, k);
    assign qtab[k] = ENTRY[SB-2:0];
  end

  logic        [TABLE_ADDR_BITS-1:0] lane_addr [2];
  logic signed [SB-1:0]              lane_val  [2];

  // Lane 0 is sin; lane 1 reads a quarter turn ahead for cos.
  always_comb begin
    lane_addr[0] = addr;
    lane_addr[1] = addr + TABLE_ADDR_BITS'(QTR);
    for (int n = 0; n < 2; n++) begin
      logic        [1:0]                 quad;
      logic        [TABLE_ADDR_BITS-3:0] rem;
      logic        [IDXW-1:0]            idx;
      logic signed [SB-1:0]              mag;
      quad = lane_addr[n][TABLE_ADDR_BITS-1 -: 2];
      rem  = lane_addr[n][TABLE_ADDR_BITS-3:0];
      idx  = quad[0] ? (IDXW'(QTR) - IDXW'(rem)) : IDXW'(rem);
      mag  = signed'({1'b0, qtab[idx]});
      lane_val[n] = quad[1] ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= lane_val[0];
      cos_val <= lane_val[1];
    end
  end

endmodule

`default_nettype wire

// ===== src/ncdm_cmul.sv =====
// ----------------------------------------------------------------------------
// NCO complex multiplier
// Multiplies the sample by the conjugate carrier; registers both sums.
// ----------------------------------------------------------------------------
`default_nettype none

module ncdm_cmul (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic signed [ncdm_pkg::SAMPLE_BITS-1:0] x_i,
  input  wire logic signed [ncdm_pkg::SAMPLE_BITS-1:0] x_q,
  input  wire logic signed [ncdm_pkg::SAMPLE_BITS-1:0] sin_val,
  input  wire logic signed [ncdm_pkg::SAMPLE_BITS-1:0] cos_val,
  output logic signed      [ncdm_pkg::SUM_BITS-1:0]    sum_i,
  output logic signed      [ncdm_pkg::SUM_BITS-1:0]    sum_q
);

  localparam int PW = 2 * ncdm_pkg::SAMPLE_BITS;

  logic signed [PW-1:0] p_ic;
  logic signed [PW-1:0] p_qs;
  logic signed [PW-1:0] p_qc;
  logic signed [PW-1:0] p_is;

  always_comb begin
    p_ic = x_i * cos_val;
    p_qs = x_q * sin_val;
    p_qc = x_q * cos_val;
    p_is = x_i * sin_val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_i <= ncdm_pkg::SUM_BITS'(p_ic) + ncdm_pkg::SUM_BITS'(p_qs);
      sum_q <= ncdm_pkg::SUM_BITS'(p_qc) - ncdm_pkg::SUM_BITS'(p_is);
    end
  end

endmodule

`default_nettype wire

// ===== src/nco_complex_down_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// NCO complex down-mixer
// Mixes a complex Q1.15 sample stream down by a programmable carrier.
// ----------------------------------------------------------------------------
// The block takes one complex sample per clock while the output side is not
// stalled, and returns one mixed sample per request. The pipeline is input
// register, sin/cos table register, product register and rounded output
// register; each stage holds its item only while the stage after it is full,
// so bubbles are squeezed out under backpressure.
// The carrier phase advances by phase_step per accepted sample, and a sample
// flagged restart is mixed at phase zero. Writes to phase_step take effect
// for samples accepted after the write.
`default_nettype none

module nco_complex_down_mixer_unit #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ncdm_pkg::STEP_BITS-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ncdm_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ncdm_pkg::out_t                      out_data
);

  localparam int SB = ncdm_pkg::SAMPLE_BITS;

  logic en1;
  logic en2;
  logic en3;
  logic en_out;
  logic accept;

  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic signed [SB-1:0]       i1;
  logic signed [SB-1:0]       q1;
  logic signed [SB-1:0]       i2;
  logic signed [SB-1:0]       q2;
  logic [TABLE_ADDR_BITS-1:0] addr0;
  logic [TABLE_ADDR_BITS-1:0] addr1;
  logic signed [SB-1:0]       sin2;
  logic signed [SB-1:0]       cos2;
  logic signed [ncdm_pkg::SUM_BITS-1:0] sum_i3;
  logic signed [ncdm_pkg::SUM_BITS-1:0] sum_q3;
  ncdm_pkg::rnd_t             rnd_i;
  ncdm_pkg::rnd_t             rnd_q;

  always_comb begin
    en_out    = !out_valid || out_ready;
    en3       = !v3 || en_out;
    en2       = !v2 || en3;
    en1       = !v1 || en2;
    in_ready  = en1;
    accept    = in_valid && in_ready;
    cfg_ready = 1'b1;
    rnd_i     = ncdm_pkg::round_sat(sum_i3);
    rnd_q     = ncdm_pkg::round_sat(sum_q3);
  end

  ncdm_nco #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_nco (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .restart   (in_data.restart),
    .addr      (addr0)
  );

  ncdm_sincos #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sincos (
    .clk     (clk),
    .en      (en2 && v1),
    .addr    (addr1),
    .sin_val (sin2),
    .cos_val (cos2)
  );

  ncdm_cmul u_cmul (
    .clk     (clk),
    .en      (en3 && v2),
    .x_i     (i2),
    .x_q     (q2),
    .sin_val (sin2),
    .cos_val (cos2),
    .sum_i   (sum_i3),
    .sum_q   (sum_q3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en_out) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i1    <= in_data.in_i;
      q1    <= in_data.in_q;
      addr1 <= addr0;
    end
    if (en2 && v1) begin
      i2 <= i1;
      q2 <= q1;
    end
    if (en_out && v3) begin
      out_data.out_i   <= rnd_i.value;
      out_data.out_q   <= rnd_q.value;
      out_data.clipped <= rnd_i.clip || rnd_q.clip;
    end
  end

endmodule

`default_nettype wire

// ===== src/ncdm_checker.sv =====
// ----------------------------------------------------------------------------
// NCO complex down-mixer checker
// Port-level properties of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ncdm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire ncdm_pkg::out_t out_data
);

  // A result that waits must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The output stage is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // A clipped result always has a part sitting at a rail.
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clipped |->
      (out_data.out_i == ncdm_pkg::SAMPLE_MAX) || (out_data.out_i == ncdm_pkg::SAMPLE_MIN) ||
      (out_data.out_q == ncdm_pkg::SAMPLE_MAX) || (out_data.out_q == ncdm_pkg::SAMPLE_MIN))
    else $error("clipped flag without a saturated part");

  // With the consumer ready the pipeline never holds back a new request.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

endmodule

bind nco_complex_down_mixer_unit ncdm_checker u_ncdm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/ncdm_mixer_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NCO down-mixer result checker
// Watches the configuration, sample and result channels, keeps its own copy
// of the carrier phase and step, predicts every mixed sample and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module ncdm_mixer_check #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [ncdm_pkg::STEP_BITS-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire ncdm_pkg::in_t                  in_data,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire ncdm_pkg::out_t                 out_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked,
  output int                                  clip_count,
  output int                                  restart_count
);

  localparam int          SAMPLE_BITS  = ncdm_pkg::SAMPLE_BITS;
  localparam int          QTR          = 1 << (TABLE_ADDR_BITS - 2);
  localparam logic [63:0] TURN_Q30     = 64'd6746518852;
  localparam longint      FULL_SCALE   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

  logic [SAMPLE_BITS-1:0] quarter_wave [0:QTR];
  logic [PHASE_BITS-1:0]  carrier_phase;
  logic [PHASE_BITS-1:0]  carrier_step;
  ncdm_pkg::out_t         mixed_q [$];

  // Quarter-wave table: truncated Taylor series of sin in Q30, then scaled
  // to full sample amplitude with rounding.
  initial begin : build_wave
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    longint      acc_sum;
    for (int k = 0; k <= QTR; k++) begin
      ang     = (TURN_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
      ang_sq  = (ang * ang) >> 30;
      term    = ang;
      acc_sum = longint'(ang);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * ang_sq) >> 30) / 64'(4 * n * n + 2 * n);
        if ((n % 2) == 1) begin
          acc_sum = acc_sum - longint'(term);
        end else begin
          acc_sum = acc_sum + longint'(term);
        end
      end
      if (acc_sum < 0) begin
        acc_sum = 0;
      end
      if (acc_sum > (longint'(1) << 30)) begin
        acc_sum = longint'(1) << 30;
      end
      quarter_wave[k] = SAMPLE_BITS'((64'(acc_sum) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30);
    end
  end

  function automatic longint wave_at(input logic [TABLE_ADDR_BITS-1:0] addr);
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-3:0] off;
    longint                     mag;
    quad = addr[TABLE_ADDR_BITS-1 -: 2];
    off  = addr[TABLE_ADDR_BITS-3:0];
    mag  = quad[0] ? longint'(quarter_wave[QTR - int'(off)]) : longint'(quarter_wave[off]);
    return quad[1] ? -mag : mag;
  endfunction

  // Round half toward plus infinity, then clamp to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] round_clamp(input longint acc_sum,
                                                                output logic sat);
    longint v;
    v   = (acc_sum + (longint'(1) << (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
    sat = 1'b0;
    if (v > longint'(ncdm_pkg::SAMPLE_MAX)) begin
      v   = longint'(ncdm_pkg::SAMPLE_MAX);
      sat = 1'b1;
    end else if (v < longint'(ncdm_pkg::SAMPLE_MIN)) begin
      v   = longint'(ncdm_pkg::SAMPLE_MIN);
      sat = 1'b1;
    end
    return SAMPLE_BITS'(v);
  endfunction

  function automatic ncdm_pkg::out_t mix_sample(input ncdm_pkg::in_t s,
                                                input logic [PHASE_BITS-1:0] ph);
    logic [TABLE_ADDR_BITS-1:0] addr;
    longint                     sin_w;
    longint                     cos_w;
    longint                     xi;
    longint                     xq;
    logic                       sat_i;
    logic                       sat_q;
    ncdm_pkg::out_t             r;
    addr      = ph[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    sin_w     = wave_at(addr);
    cos_w     = wave_at(addr + TABLE_ADDR_BITS'(QTR));
    xi        = longint'($signed(s.in_i));
    xq        = longint'($signed(s.in_q));
    r.out_i   = round_clamp(xi * cos_w + xq * sin_w, sat_i);
    r.out_q   = round_clamp(xq * cos_w - xi * sin_w, sat_q);
    r.clipped = sat_i | sat_q;
    return r;
  endfunction

  always @(posedge clk) begin : track
    ncdm_pkg::out_t        want;
    logic [PHASE_BITS-1:0] ph;
    int                    bad;
    bad = 0;
    if (rst) begin
      carrier_phase = '0;
      carrier_step  = PHASE_BITS'(ncdm_pkg::STEP_RESET);
      mixed_q.delete();
      errors        <= 0;
      checked       <= 0;
      clip_count    <= 0;
      restart_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        carrier_step = PHASE_BITS'(cfg_data);
      end
      // Results are retired before new requests are queued, so a result that
      // appears with no expectation is never matched to a fresh one.
      if (out_valid && out_ready) begin
        if (mixed_q.size() == 0) begin
          $display("%0t: result with no request pending: i=%0d q=%0d clipped=%0b",
                   $time, out_data.out_i, out_data.out_q, out_data.clipped);
          bad++;
        end else begin
          want = mixed_q.pop_front();
          if (out_data.out_i !== want.out_i) begin
            $display("%0t: out_i expected %0d, got %0d", $time, want.out_i, out_data.out_i);
            bad++;
          end
          if (out_data.out_q !== want.out_q) begin
            $display("%0t: out_q expected %0d, got %0d", $time, want.out_q, out_data.out_q);
            bad++;
          end
          if (out_data.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0b, got %0b", $time, want.clipped,
                     out_data.clipped);
            bad++;
          end
          checked <= checked + 1;
          if (want.clipped) begin
            clip_count <= clip_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        ph            = in_data.restart ? '0 : carrier_phase;
        carrier_phase = ph + carrier_step;
        mixed_q.push_back(mix_sample(in_data, ph));
        if (in_data.restart) begin
          restart_count <= restart_count + 1;
        end
      end
      errors <= errors + bad;
    end
    pending <= mixed_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NCO down-mixer testbench
// Drives directed and random complex samples through the mixer under several
// carrier steps, with bursty requests and a stalling receiver; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          SAMPLE_BITS     = ncdm_pkg::SAMPLE_BITS;
  localparam int          STEP_BITS       = ncdm_pkg::STEP_BITS;
  localparam int          RANDOM_PHASES   = 11;
  localparam int          ITEMS_PER_PHASE = 139;
  localparam int          PIPE_DRAIN      = 12;
  localparam longint      LIMIT_NS        = 5_000_000;
  localparam logic [STEP_BITS-1:0] STEP_EIGHTH = 32'h2000_0000;

  typedef enum logic [1:0] {RX_STREAM, RX_HALF, RX_SPARSE, RX_SQUARE} rx_mode_e;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [STEP_BITS-1:0] cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  ncdm_pkg::in_t        in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ncdm_pkg::out_t       out_data;

  int       errors;
  int       pending;
  int       checked;
  int       clip_count;
  int       restart_count;
  int       sent        = 0;
  int       step_writes = 0;
  int       burst_left  = 0;
  bit       steady      = 1'b0;
  rx_mode_e rx_mode     = RX_STREAM;
  int       rx_left     = 0;

  nco_complex_down_mixer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ncdm_mixer_check mix_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .clip_count    (clip_count),
    .restart_count (restart_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("nco_complex_down_mixer_unit: mismatch");
    $finish;
  end

  // The receiver switches at random between stall patterns.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 128);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: begin
        out_ready <= 1'b1;
      end
      RX_HALF: begin
        out_ready <= ($urandom_range(0, 1) == 0);
      end
      RX_SPARSE: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= rx_left[2];
      end
    endcase
  end

  function automatic ncdm_pkg::in_t mk(input logic [SAMPLE_BITS-1:0] i,
                                       input logic [SAMPLE_BITS-1:0] q,
                                       input logic restart);
    ncdm_pkg::in_t s;
    s.in_i    = i;
    s.in_q    = q;
    s.restart = restart;
    return s;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_part();
    case ($urandom_range(0, 7))
      0: begin
        return ncdm_pkg::SAMPLE_MAX;
      end
      1: begin
        return ncdm_pkg::SAMPLE_MIN;
      end
      default: begin
        return SAMPLE_BITS'($urandom);
      end
    endcase
  endfunction

  // Sends one request and, at the end of a burst, may leave a gap.
  task automatic feed(input ncdm_pkg::in_t s);
    int gap;
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_BITS-1:0] step);
    drain();
    cfg_data  <= step;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_writes++;
  endtask

  initial begin
    logic [STEP_BITS-1:0] next_step;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset step: zero phase, rounding ties, full-scale corners and clipping.
    feed(mk(16'h0000, 16'h0000, 1'b1));
    feed(mk(16'h7FFF, 16'h7FFF, 1'b1));
    feed(mk(16'h8000, 16'h8000, 1'b1));
    feed(mk(16'h4000, 16'hC000, 1'b1));
    feed(mk(16'hC000, 16'h4000, 1'b1));
    feed(mk(16'h7FFF, 16'h7FFF, 1'b0));
    feed(mk(16'h8000, 16'h8000, 1'b0));
    feed(mk(16'h7FFF, 16'h8000, 1'b0));
    feed(mk(16'h8000, 16'h7FFF, 1'b0));
    feed(mk(16'hFFFF, 16'h0001, 1'b0));
    feed(mk(16'h0001, 16'hFFFF, 1'b0));
    feed(mk(16'h0000, 16'h8000, 1'b0));
    feed(mk(16'h8000, 16'h0000, 1'b0));
    feed(mk(16'h5A5A, 16'hA5A5, 1'b0));
    feed(mk(16'h7FFF, 16'h8000, 1'b1));
    feed(mk(16'hA5A5, 16'h5A5A, 1'b0));

    // An eighth of a turn per sample walks the carrier through every octant.
    write_step(STEP_EIGHTH);
    feed(mk(16'h7FFF, 16'h7FFF, 1'b1));
    for (int n = 0; n < 8; n++) begin
      feed(mk(n[0] ? 16'h8000 : 16'h7FFF, n[1] ? 16'h8000 : 16'h7FFF, 1'b0));
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          next_step = '0;
        end
        1: begin
          next_step = '1;
        end
        2: begin
          next_step = 32'd1;
        end
        3: begin
          next_step = 32'h8000_0000;
        end
        4: begin
          next_step = 32'h4000_0000;
        end
        RANDOM_PHASES - 1: begin
          next_step = ncdm_pkg::STEP_RESET;
        end
        default: begin
          next_step = $urandom;
        end
      endcase
      write_step(next_step);
      steady = (p == 6);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the sender once mid-stream until the pipeline has emptied.
        if (p == 3 && n == ITEMS_PER_PHASE / 2) begin
          drain();
        end
        feed(mk(pick_part(), pick_part(), $urandom_range(0, 31) == 0));
      end
    end

    drain();
    $display("Sent %0d samples under %0d carrier step writes plus the reset step.",
             sent, step_writes);
    $display("Checked %0d results, %0d of them clipped; %0d samples restarted the phase.",
             checked, clip_count, restart_count);
    if (errors == 0) begin
      $display("nco_complex_down_mixer_unit: match");
    end else begin
      $display("nco_complex_down_mixer_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ncdm_pkg.sv
src/ncdm_nco.sv
src/ncdm_sincos.sv
src/ncdm_cmul.sv
src/nco_complex_down_mixer_unit.sv
src/ncdm_checker.sv
tb/ncdm_mixer_check.sv
tb/testbench.sv
